[src/spc_pkg.sv]
// Shared types, codes and constants for the stepper position controller.
// No dependencies; imported by spc_step_logic, stepper_position_controller, spc_checker and tb_top.
`default_nettype none

package spc_pkg;

   // Default width of the position, goal and span counters
   localparam int POSITION_BITS_DEFAULT = 16;

   // Position after reset, truncated to the counter width
   localparam int RESET_POSITION = 5000;

   // Step stride after reset: full-step
   localparam logic [1:0] RESET_STRIDE = 2'd2;

   // Action codes carried in the request word
   localparam logic [1:0] ACTION_TICK     = 2'd0;
   localparam logic [1:0] ACTION_SET_GOAL = 2'd1;
   localparam logic [1:0] ACTION_HOME     = 2'd2;

   // Homing sequencer, one-hot
   typedef enum logic [3:0] {
      HOME_IDLE      = 4'b0001,
      HOME_SEEK_LEFT = 4'b0010,
      HOME_SEEK_FAR  = 4'b0100,
      HOME_WALK_BACK = 4'b1000
   } home_state_type;

   // Control state handed between the state registers and the step logic
   typedef struct packed {
      home_state_type home;
      logic           swapped;
      logic [2:0]     phase_index;
      logic [3:0]     coil;
   } spc_ctrl_type;

   // Request word
   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] goal_position;
      logic        left_limit;
      logic        right_limit;
   } req_type;

   // Response word
   typedef struct packed {
      logic [3:0]  coil_pattern;
      logic [15:0] position;
      logic        at_goal;
      logic        homing_busy;
      logic        limits_swapped;
      logic [15:0] travel_span;
   } rsp_type;

   // Half-step coil table, coil A in bit 0
   function automatic logic [3:0] coil_lookup(input logic [2:0] idx);
      logic [3:0] pattern;
      unique case (idx)
         3'd0: pattern = 4'h9;
         3'd1: pattern = 4'h8;
         3'd2: pattern = 4'hA;
         3'd3: pattern = 4'h2;
         3'd4: pattern = 4'h6;
         3'd5: pattern = 4'h4;
         3'd6: pattern = 4'h5;
         default: pattern = 4'h1;
      endcase
      return pattern;
   endfunction

endpackage

`default_nettype wire

[src/stepper_position_controller.sv]
// Stepper position controller top level: request register, state registers,
// response register. Depends on spc_pkg and spc_step_logic.
`default_nettype none

// Takes one request word per clock while req_stall is low and returns one
// response word for each, in order. A word is held in the request register,
// the step logic updates the motor state as it moves on, and the response
// waits in the response register until taken; with no back-pressure the
// throughput is one word per cycle. A tick moves the motor at most one step
// toward the goal, or advances the homing run by one step.
// Write csr_write_data (step stride) only while no word is in flight.
module stepper_position_controller
   import spc_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_write_data
);

   localparam spc_ctrl_type CTRL_RESET = '{
      home:        HOME_IDLE,
      swapped:     1'b0,
      phase_index: 3'd0,
      coil:        4'h0
   };

   logic                     in_valid_ff, in_valid_in;
   req_type                  in_data_ff;
   logic                     out_valid_ff, out_valid_in;
   rsp_type                  out_data_ff;
   logic [1:0]               stride_ff;
   spc_ctrl_type             ctrl_ff, ctrl_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] goal_ff, goal_in;
   logic [POSITION_BITS-1:0] span_ff, span_in;
   rsp_type                  result;
   logic                     accept;
   logic                     advance;

   // Handshake: the request word moves on when the response slot is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = accept || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   // Step logic
   spc_step_logic #(
      .POSITION_BITS(POSITION_BITS)
   ) u_step (
      .stride    (stride_ff),
      .item      (in_data_ff),
      .ctrl_cur  (ctrl_ff),
      .pos_cur   (pos_ff),
      .goal_cur  (goal_ff),
      .span_cur  (span_ff),
      .ctrl_next (ctrl_in),
      .pos_next  (pos_in),
      .goal_next (goal_in),
      .span_next (span_in),
      .result    (result)
   );

   // Control and motor state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         stride_ff    <= RESET_STRIDE;
         ctrl_ff      <= CTRL_RESET;
         pos_ff       <= POSITION_BITS'(RESET_POSITION);
         goal_ff      <= '0;
         span_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            stride_ff <= csr_write_data;
         end
         if (advance) begin
            ctrl_ff <= ctrl_in;
            pos_ff  <= pos_in;
            goal_ff <= goal_in;
            span_ff <= span_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

[src/spc_step_logic.sv]
// Combinational next-state and response logic for one request word.
// Depends on spc_pkg (types, action codes, coil table).
`default_nettype none

module spc_step_logic
   import spc_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  wire logic [1:0]               stride,
   input  wire req_type                  item,
   input  wire spc_ctrl_type             ctrl_cur,
   input  wire logic [POSITION_BITS-1:0] pos_cur,
   input  wire logic [POSITION_BITS-1:0] goal_cur,
   input  wire logic [POSITION_BITS-1:0] span_cur,
   output spc_ctrl_type                  ctrl_next,
   output logic [POSITION_BITS-1:0]      pos_next,
   output logic [POSITION_BITS-1:0]      goal_next,
   output logic [POSITION_BITS-1:0]      span_next,
   output rsp_type                       result
);

   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   logic [2:0] phase_right;
   logic [2:0] phase_left;
   logic       step_right;
   logic       step_left;
   logic       far_hit;

   // Phase index one step either way
   assign phase_right = ctrl_cur.phase_index + {1'b0, stride};
   assign phase_left  = ctrl_cur.phase_index - {1'b0, stride};
   assign far_hit     = ctrl_cur.swapped ? item.left_limit : item.right_limit;

   // Main update
   always_comb begin
      ctrl_next  = ctrl_cur;
      pos_next   = pos_cur;
      goal_next  = goal_cur;
      span_next  = span_cur;
      step_right = 1'b0;
      step_left  = 1'b0;

      case (item.action)
         ACTION_TICK: begin
            unique case (ctrl_cur.home)
               HOME_IDLE: begin
                  if (pos_cur > goal_cur) begin
                     step_left = 1'b1;
                     pos_next  = pos_cur - POS_ONE;
                  end else if (pos_cur < goal_cur) begin
                     step_right = 1'b1;
                     pos_next   = pos_cur + POS_ONE;
                  end
               end
               HOME_SEEK_LEFT: begin
                  if (item.left_limit) begin
                     ctrl_next.swapped = 1'b0;
                     ctrl_next.home    = HOME_SEEK_FAR;
                  end else if (item.right_limit) begin
                     ctrl_next.swapped = 1'b1;
                     ctrl_next.home    = HOME_SEEK_FAR;
                  end else begin
                     // position stays at zero while seeking
                     step_left = 1'b1;
                  end
               end
               HOME_SEEK_FAR: begin
                  if (far_hit) begin
                     pos_next       = span_cur;
                     ctrl_next.home = HOME_WALK_BACK;
                  end else begin
                     step_right = 1'b1;
                     if (span_cur != POS_MAX) begin
                        span_next = span_cur + POS_ONE;
                     end
                  end
               end
               default: begin
                  // walk back to the middle of the span
                  if (pos_cur == (span_cur >> 1)) begin
                     goal_next      = pos_cur;
                     ctrl_next.home = HOME_IDLE;
                  end else begin
                     step_left = 1'b1;
                     pos_next  = pos_cur - POS_ONE;
                  end
               end
            endcase
         end
         ACTION_SET_GOAL: begin
            if (ctrl_cur.home == HOME_IDLE) begin
               goal_next = POSITION_BITS'(item.goal_position);
            end
         end
         ACTION_HOME: begin
            pos_next          = '0;
            goal_next         = '0;
            span_next         = '0;
            ctrl_next.swapped = 1'b0;
            ctrl_next.home    = HOME_SEEK_LEFT;
         end
         default: begin
            // unused code: state unchanged
         end
      endcase

      // Coil phase advance
      if (step_right) begin
         ctrl_next.phase_index = phase_right;
         ctrl_next.coil        = coil_lookup(phase_right);
      end else if (step_left) begin
         ctrl_next.phase_index = phase_left;
         ctrl_next.coil        = coil_lookup(phase_left);
      end
   end

   // Response from the updated state
   always_comb begin
      result.coil_pattern   = ctrl_next.coil;
      result.position       = 16'(pos_next);
      result.at_goal        = (pos_next == goal_next);
      result.homing_busy    = (ctrl_next.home != HOME_IDLE);
      result.limits_swapped = ctrl_next.swapped;
      result.travel_span    = 16'(span_next);
   end

endmodule

`default_nettype wire

[dv/spc_checker.sv]
// Response checker for the stepper position controller: follows the request, response
// and stride ports, predicts every response word and compares it field by field.
// Depends on spc_pkg.
module spc_checker
   import spc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_stall,
   input  wire req_type    req_data,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  wire rsp_type    rsp_data,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_write_data,
   output int              fail_count,
   output int              words_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   // Half-step drive sequence, coil A in bit 0
   localparam logic [3:0] COIL_SEQUENCE [0:7] =
      '{4'h9, 4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h1};
   localparam logic [15:0] SPAN_MAX = 16'hFFFF;
   localparam int PRINT_LIMIT = 50;

   // Predicted motor state
   logic [1:0]     stride;
   logic [2:0]     phase_idx;
   logic [15:0]    motor_pos;
   logic [15:0]    goal;
   logic [15:0]    span;
   home_state_type home;
   logic           swapped;
   logic [3:0]     coil;

   // Predicted response words, oldest first
   rsp_type expected_words [$];

   // One step of the coil phase, right is up the table
   function automatic void step_coils(input logic rightward);
      if (rightward) begin
         phase_idx = phase_idx + 3'(stride);
      end else begin
         phase_idx = phase_idx - 3'(stride);
      end
      coil = COIL_SEQUENCE[phase_idx];
   endfunction

   // A tick: move toward the goal, or advance the homing run by one step
   function automatic void motor_tick(input logic left, input logic right);
      logic far_hit;
      far_hit = swapped ? left : right;
      case (home)
         HOME_IDLE: begin
            if (motor_pos > goal) begin
               step_coils(1'b0);
               motor_pos = motor_pos - 16'd1;
            end else if (motor_pos < goal) begin
               step_coils(1'b1);
               motor_pos = motor_pos + 16'd1;
            end
         end
         HOME_SEEK_LEFT: begin
            // whichever switch trips first is taken as the left one
            if (left) begin
               swapped = 1'b0;
               home = HOME_SEEK_FAR;
            end else if (right) begin
               swapped = 1'b1;
               home = HOME_SEEK_FAR;
            end else begin
               step_coils(1'b0);
            end
         end
         HOME_SEEK_FAR: begin
            if (far_hit) begin
               motor_pos = span;
               home = HOME_WALK_BACK;
            end else begin
               step_coils(1'b1);
               if (span != SPAN_MAX) span = span + 16'd1;
            end
         end
         HOME_WALK_BACK: begin
            if (motor_pos == (span >> 1)) begin
               goal = motor_pos;
               home = HOME_IDLE;
            end else begin
               step_coils(1'b0);
               motor_pos = motor_pos - 16'd1;
            end
         end
         default: ;
      endcase
   endfunction

   // Applies one request word and returns the response it should give
   function automatic rsp_type predict_response(input req_type w);
      rsp_type r;
      case (w.action)
         ACTION_TICK: motor_tick(w.left_limit, w.right_limit);
         ACTION_SET_GOAL: begin
            // homing owns the goal while it runs
            if (home == HOME_IDLE) goal = w.goal_position;
         end
         ACTION_HOME: begin
            motor_pos = '0;
            goal = '0;
            span = '0;
            swapped = 1'b0;
            home = HOME_SEEK_LEFT;
         end
         default: ;
      endcase
      r.coil_pattern = coil;
      r.position = motor_pos;
      r.at_goal = (motor_pos == goal);
      r.homing_busy = (home != HOME_IDLE);
      r.limits_swapped = swapped;
      r.travel_span = span;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic compare_word(input rsp_type got, input rsp_type want);
      if (got.coil_pattern !== want.coil_pattern)
         report_mismatch("coil_pattern", got.coil_pattern, want.coil_pattern);
      if (got.position !== want.position)
         report_mismatch("position", got.position, want.position);
      if (got.at_goal !== want.at_goal)
         report_mismatch("at_goal", got.at_goal, want.at_goal);
      if (got.homing_busy !== want.homing_busy)
         report_mismatch("homing_busy", got.homing_busy, want.homing_busy);
      if (got.limits_swapped !== want.limits_swapped)
         report_mismatch("limits_swapped", got.limits_swapped, want.limits_swapped);
      if (got.travel_span !== want.travel_span)
         report_mismatch("travel_span", got.travel_span, want.travel_span);
   endtask

   // Response taken before request so a word never meets its own prediction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         stride = RESET_STRIDE;
         phase_idx = '0;
         motor_pos = 16'(RESET_POSITION);
         goal = '0;
         span = '0;
         home = HOME_IDLE;
         swapped = 1'b0;
         coil = '0;
         expected_words.delete();
      end else begin
         if (csr_write_enable) stride = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected response word, position", rsp_data.position, -1);
            end else begin
               want = expected_words.pop_front();
               compare_word(rsp_data, want);
            end
         end
         if (req_valid && !req_stall) expected_words.push_back(predict_response(req_data));
      end
      words_in_flight <= expected_words.size();
   end

endmodule

[dv/tb_top.sv]
// Testbench top for the stepper position controller: clock, reset, request and
// stride stimulus, response back-pressure and the verdict.
// Depends on spc_pkg, stepper_position_controller and spc_checker.
module tb_top
   import spc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACTION_UNUSED = 2'd3;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int STALL_LIMIT = 1000;
   localparam int PHASE_WORDS = 300;
   localparam int SETTLE_CYCLES = 4;
   // stride per random phase: half, three half-steps, none, full, half
   localparam logic [1:0] STRIDE_PLAN [0:4] = '{2'd1, 2'd3, 2'd0, 2'd2, 2'd1};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_write_data = RESET_STRIDE;

   int fail_count;
   int words_in_flight;
   int words_sent = 0;
   int quiet_cycles = 0;
   bit sender_idling = 1'b0;
   bit receiver_idling = 1'b0;
   bit long_hold_due = 1'b0;
   // rough track of where the motor rests, for picking nearby goals
   int motor_at = 0;
   bit motor_known = 1'b0;

   stepper_position_controller uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   spc_checker response_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .words_in_flight  (words_in_flight)
   );

   always #5 clock = ~clock;

   // Watchdog: too long without any word moving ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[stepper_position_controller] ERROR");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_idling && $urandom_range(0, 11) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type make_word(input logic [1:0] act, input logic [15:0] g,
                                         input logic l, input logic r);
      req_type w;
      w.action = act;
      w.goal_position = g;
      w.left_limit = l;
      w.right_limit = r;
      return w;
   endfunction

   // Tick with a junk goal field, which the block must ignore
   function automatic req_type tick_word(input logic l, input logic r);
      return make_word(ACTION_TICK, 16'($urandom), l, r);
   endfunction

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   // Offers one word, with an occasional gap ahead of it, and waits for acceptance
   task automatic send_word(input req_type w);
      if (sender_idling && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_data <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
   endtask

   // Stride changes only with nothing in flight
   task automatic write_stride(input logic [1:0] s);
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_data <= s;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Full homing run: seek left, seek far for span_len steps, walk back and settle
   task automatic home_run(input int span_len, input bit cross_wired);
      int i;
      send_word(make_word(ACTION_HOME, 16'($urandom), coin(), coin()));
      repeat ($urandom_range(0, 4)) send_word(tick_word(1'b0, 1'b0));
      if (cross_wired) begin
         send_word(tick_word(1'b0, 1'b1));
      end else begin
         send_word(tick_word(1'b1, coin()));
      end
      for (i = 0; i < span_len; i++) begin
         if ($urandom_range(0, 15) == 0)
            send_word(make_word(ACTION_SET_GOAL, 16'($urandom), coin(), coin()));
         send_word(cross_wired ? tick_word(1'b0, coin()) : tick_word(coin(), 1'b0));
      end
      send_word(cross_wired ? tick_word(1'b1, coin()) : tick_word(coin(), 1'b1));
      repeat (span_len - span_len / 2 + 1 + $urandom_range(0, 2))
         send_word(tick_word(coin(), coin()));
      motor_at = span_len / 2;
      motor_known = 1'b1;
   endtask

   // New goal near the motor, then enough ticks to get there and idle a little
   task automatic move_by(input int delta);
      int target;
      int distance;
      target = motor_at + delta;
      if (target < 0) target = 0;
      if (target > 65535) target = 65535;
      distance = (target > motor_at) ? target - motor_at : motor_at - target;
      send_word(make_word(ACTION_SET_GOAL, 16'(target), coin(), coin()));
      repeat (distance + $urandom_range(0, 3)) send_word(tick_word(coin(), coin()));
      motor_at = target;
   endtask

   // Fully random words, unused action code included
   task automatic noise_burst(input int count);
      repeat (count)
         send_word(make_word(2'($urandom_range(0, 3)), 16'($urandom), coin(), coin()));
      motor_known = 1'b0;
   endtask

   task automatic run_episode();
      int pick;
      int delta;
      pick = $urandom_range(0, 99);
      delta = $urandom_range(0, 80);
      delta = delta - 40;
      if (pick < 30 || !motor_known) begin
         if ($urandom_range(0, 9) == 0) begin
            home_run($urandom_range(100, 300), coin());
         end else begin
            home_run($urandom_range(0, 40), coin());
         end
      end else if (pick < 80) begin
         move_by(delta);
      end else begin
         noise_burst($urandom_range(5, 20));
      end
   endtask

   // Main stimulus
   initial begin
      int phase;
      int phase_end;
      bit paused;
      paused = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle moves, goal extremes, unused code, homing with restart
      send_word(tick_word(1'b0, 1'b0));
      send_word(make_word(ACTION_UNUSED, 16'hFFFF, 1'b1, 1'b1));
      send_word(make_word(ACTION_SET_GOAL, 16'd4999, 1'b0, 1'b0));
      send_word(tick_word(1'b1, 1'b1));
      send_word(make_word(ACTION_SET_GOAL, 16'hFFFF, 1'b1, 1'b0));
      send_word(tick_word(1'b0, 1'b0));
      send_word(make_word(ACTION_SET_GOAL, 16'h0000, 1'b0, 1'b1));
      send_word(tick_word(1'b0, 1'b0));
      send_word(make_word(ACTION_HOME, 16'hFFFF, 1'b1, 1'b1));
      send_word(tick_word(1'b0, 1'b0));
      send_word(make_word(ACTION_SET_GOAL, 16'h5A5A, 1'b0, 1'b0));
      send_word(make_word(ACTION_HOME, 16'h0000, 1'b0, 1'b0));
      send_word(tick_word(1'b1, 1'b1));
      send_word(tick_word(1'b1, 1'b0));
      send_word(tick_word(1'b0, 1'b0));
      send_word(tick_word(1'b0, 1'b1));
      send_word(tick_word(1'b0, 1'b0));
      send_word(tick_word(1'b0, 1'b0));
      send_word(tick_word(1'b0, 1'b0));
      // swapped wiring: right switch seen first
      send_word(make_word(ACTION_HOME, 16'h0000, 1'b0, 1'b0));
      send_word(tick_word(1'b0, 1'b1));
      send_word(tick_word(1'b0, 1'b1));
      send_word(tick_word(1'b1, 1'b0));
      send_word(tick_word(1'b0, 1'b0));
      send_word(tick_word(1'b0, 1'b0));
      motor_at = 0;
      motor_known = 1'b1;

      // Random phases, one stride setting each
      for (phase = 0; phase < 5; phase++) begin
         sender_idling = (phase != 3);
         receiver_idling = (phase != 3);
         write_stride(STRIDE_PLAN[phase]);
         if (phase == 1) long_hold_due = 1'b1;
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) begin
            if (phase == 2 && !paused && words_sent > phase_end - PHASE_WORDS / 2) begin
               wait_for_responses();
               paused = 1'b1;
            end
            run_episode();
         end
      end

      // Last part: no idling, full step, then a cross-wired homing run
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      write_stride(2'd2);
      phase_end = words_sent + 100;
      while (words_sent < phase_end) run_episode();
      home_run(8, 1'b1);

      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && words_in_flight == 0) begin
         $display("[stepper_position_controller] OK");
      end else begin
         $display("[stepper_position_controller] ERROR");
      end
      $finish;
   end

endmodule
